@@ src/cbe_pkg.sv @@
// Shared types and constants for the buffered Coulomb pair energy and force block.
`default_nettype none
package cbe_pkg;

    localparam logic [24:0] K_COUL  = 25'd21762644;
    localparam logic [11:0] BUF_OFS = 12'd3277;
    localparam logic signed [47:0] MAX47 = 48'sh7FFF_FFFF_FFFF;
    localparam logic signed [47:0] MIN47 = 48'sh8000_0000_0000;

    localparam logic [15:0] SCALE_ONE_FOUR_RST = 16'd49152;
    localparam logic [31:0] FORCE_SCALE_RST    = 32'd65536;
    localparam logic [15:0] MIN_DISTANCE_RST   = 16'd7;

    localparam int MUL_W   = 48;
    localparam int DIG_W   = 16;
    localparam int MUL_DIG = MUL_W / DIG_W;

    localparam logic [6:0] QB_ENERGY = 7'd36;
    localparam logic [6:0] QB_FORCE  = 7'd40;
    localparam logic [6:0] QB_UNIT   = 7'd31;

    typedef enum logic [1:0] {
        CFG_SCALE_ONE_FOUR = 2'd0,
        CFG_FORCE_SCALE    = 2'd1,
        CFG_MIN_DISTANCE   = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic [15:0] scale_one_four;
        logic [31:0] force_scale;
        logic [15:0] min_distance;
    } t_cfg;

    typedef struct packed {
        logic [2:0][32:0] dmag;
        logic [2:0]       dneg;
        logic [30:0]      qmag;
        logic             qneg;
        logic             one_four;
        logic             last;
    } t_pair;

    typedef struct packed {
        logic signed [47:0] force_x;
        logic signed [47:0] force_y;
        logic signed [47:0] force_z;
        logic signed [47:0] pair_energy;
        logic signed [47:0] total_energy;
        logic               is_final;
        logic               too_close;
    } t_result;

endpackage
`default_nettype wire

@@ src/cbe_fifo.sv @@
// Small show-ahead queue used between the stages and on the result side.
`default_nettype none
module cbe_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_data,
    output logic                  o_full,
    input  wire logic             i_pop,
    output logic [WIDTH-1:0]      o_data,
    output logic                  o_empty
);
    // DEPTH must be a power of two, at least 2
    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wp, r_rp;
    logic [CW-1:0]    r_cnt;
    logic             wr, rd;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign wr      = i_push && !o_full;
    assign rd      = i_pop && !o_empty;
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (wr) begin
            r_mem[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (wr) begin
                r_wp <= r_wp + 1'b1;
            end
            if (rd) begin
                r_rp <= r_rp + 1'b1;
            end
            case ({wr, rd})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end
endmodule
`default_nettype wire

@@ src/cbe_front.sv @@
// Front stage: takes a pair, forms separation magnitudes and signs and the charge product.
`default_nettype none
module cbe_front
    import cbe_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_push,
    output logic                    o_full,
    input  wire logic signed [31:0] i_first_x,
    input  wire logic signed [31:0] i_first_y,
    input  wire logic signed [31:0] i_first_z,
    input  wire logic signed [31:0] i_second_x,
    input  wire logic signed [31:0] i_second_y,
    input  wire logic signed [31:0] i_second_z,
    input  wire logic signed [15:0] i_first_charge,
    input  wire logic signed [15:0] i_second_charge,
    input  wire logic               i_pair_one_four,
    input  wire logic               i_pair_last,
    input  wire logic               i_q_full,
    output logic                    o_q_push,
    output t_pair                   o_pair
);
    logic               r_valid;
    t_pair              r_pair;
    t_pair              pair;
    logic signed [32:0] d [3];
    logic signed [31:0] qq;
    logic               accept;

    assign d[0] = 33'(i_first_x) - 33'(i_second_x);
    assign d[1] = 33'(i_first_y) - 33'(i_second_y);
    assign d[2] = 33'(i_first_z) - 33'(i_second_z);
    assign qq   = i_first_charge * i_second_charge;

    always_comb begin
        pair = '0;
        for (int c = 0; c < 3; c++) begin
            pair.dneg[c] = d[c][32];
            pair.dmag[c] = d[c][32] ? 33'(-d[c]) : 33'(d[c]);
        end
        pair.qneg     = qq[31];
        pair.qmag     = qq[31] ? 31'(-qq) : 31'(qq);
        pair.one_four = i_pair_one_four;
        pair.last     = i_pair_last;
    end

    assign o_full   = r_valid && i_q_full;
    assign accept   = i_push && !o_full;
    assign o_q_push = r_valid && !i_q_full;
    assign o_pair   = r_pair;

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_pair <= pair;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (o_q_push) begin
            r_valid <= 1'b0;
        end
    end
endmodule
`default_nettype wire

@@ src/cbe_mul.sv @@
// Shared multiplier: 48 by 48 bits, one 16-bit digit of the second operand per cycle.
`default_nettype none
module cbe_mul
    import cbe_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    input  wire logic [MUL_W-1:0]   i_a,
    input  wire logic [MUL_W-1:0]   i_b,
    output logic                    o_done,
    output logic [2*MUL_W-1:0]      o_p
);
    logic [MUL_W-1:0]   r_a, r_b;
    logic [2*MUL_W-1:0] r_acc;
    logic [1:0]         r_cnt;
    logic               r_busy, r_done;
    logic [MUL_W+DIG_W-1:0] part;

    assign part   = r_a * r_b[MUL_W-1 -: DIG_W];
    assign o_p    = r_acc;
    assign o_done = r_done;

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a   <= i_a;
            r_b   <= i_b;
            r_acc <= '0;
        end else if (r_busy) begin
            r_acc <= (r_acc << DIG_W) + (2*MUL_W)'(part);
            r_b   <= r_b << DIG_W;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == 2'(MUL_DIG - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end
endmodule
`default_nettype wire

@@ src/cbe_div.sv @@
// Shared restoring divider, one quotient bit per cycle, quotient width given per call.
`default_nettype none
module cbe_div (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic [63:0] i_n,
    input  wire logic [63:0] i_d,
    input  wire logic [6:0]  i_qbits,
    output logic             o_done,
    output logic [63:0]      o_q
);
    logic [63:0] r_rem, r_quo, r_d;
    logic [6:0]  r_cnt;
    logic        r_busy, r_done;
    logic [64:0] t;
    logic        ge;

    // quotient must fit in i_qbits, so the top part of the dividend is already below d
    assign t      = {r_rem, r_quo[63]};
    assign ge     = (t >= {1'b0, r_d});
    assign o_q    = r_quo;
    assign o_done = r_done;

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= i_n >> i_qbits;
            r_quo <= i_n << (7'd64 - i_qbits);
            r_d   <= i_d;
        end else if (r_busy) begin
            r_rem <= ge ? 64'(t - {1'b0, r_d}) : t[63:0];
            r_quo <= {r_quo[62:0], ge};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_qbits;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == 7'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end
endmodule
`default_nettype wire

@@ src/cbe_back.sv @@
// Back stage: sequencer for distance, energy, force magnitude and projection, plus the sum.
`default_nettype none
module cbe_back
    import cbe_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire t_cfg  i_cfg,
    input  wire logic  i_q_empty,
    input  wire t_pair i_q_data,
    output logic       o_q_pop,
    input  wire logic  i_out_full,
    output logic       o_out_push,
    output t_result    o_out_data
);
    typedef enum logic [13:0] {
        ST_IDLE  = 14'b00000000000001,
        ST_SQ    = 14'b00000000000010,
        ST_ROOT  = 14'b00000000000100,
        ST_CHECK = 14'b00000000001000,
        ST_KQ    = 14'b00000000010000,
        ST_DIVE  = 14'b00000000100000,
        ST_DEN2  = 14'b00000001000000,
        ST_DIVF  = 14'b00000010000000,
        ST_SCE   = 14'b00000100000000,
        ST_SCF   = 14'b00001000000000,
        ST_FS    = 14'b00010000000000,
        ST_DIVU  = 14'b00100000000000,
        ST_MU    = 14'b01000000000000,
        ST_EMIT  = 14'b10000000000000
    } t_state;

    t_state             r_state;
    t_pair              r_item;
    logic               r_go;
    logic [1:0]         r_c;
    logic [65:0]        r_sum2;
    logic [67:0]        r_rad;
    logic [34:0]        r_srem;
    logic [33:0]        r_root;
    logic [5:0]         r_scnt;
    logic               r_close;
    logic [54:0]        r_kq;
    logic [35:0]        r_emag;
    logic [67:0]        r_den2;
    logic [46:0]        r_fmag;
    logic [30:0]        r_u;
    logic [46:0]        r_fc [3];
    logic signed [47:0] r_energy_sum;

    logic               mul_start, mul_done;
    logic [MUL_W-1:0]   mul_a, mul_b;
    logic [2*MUL_W-1:0] mul_p;
    logic               div_start, div_done;
    logic [63:0]        div_n, div_d, div_q;
    logic [6:0]         div_qbits;

    logic [34:0]        den;
    logic               den_small;
    logic [36:0]        srem_t, strial;
    logic               sge;
    logic signed [47:0] e, fv [3];
    logic signed [48:0] s_wide;
    logic signed [47:0] s_sat;

    assign den       = {1'b0, r_root} + 35'(BUF_OFS);
    assign den_small = (den[34:32] == 3'b000);

    assign srem_t = {r_srem, r_rad[67:66]};
    assign strial = {1'b0, r_root, 2'b01};
    assign sge    = (srem_t >= strial);

    always_comb begin
        mul_a     = '0;
        mul_b     = '0;
        mul_start = 1'b0;
        div_n     = '0;
        div_d     = '0;
        div_qbits = QB_UNIT;
        div_start = 1'b0;
        unique case (r_state)
            ST_SQ: begin
                mul_a     = 48'(r_item.dmag[r_c]);
                mul_b     = 48'(r_item.dmag[r_c]);
                mul_start = r_go;
            end
            ST_KQ: begin
                mul_a     = 48'(K_COUL);
                mul_b     = 48'(r_item.qmag);
                mul_start = r_go;
            end
            ST_DIVE: begin
                div_n     = 64'(r_kq);
                div_d     = 64'({den, 8'h00});
                div_qbits = QB_ENERGY;
                div_start = r_go;
            end
            ST_DEN2: begin
                mul_a     = 48'(den);
                mul_b     = 48'(den);
                mul_start = r_go;
            end
            ST_DIVF: begin
                div_n     = 64'({r_kq, 8'h00});
                div_d     = r_den2[63:0];
                div_qbits = QB_FORCE;
                div_start = r_go && den_small;
            end
            ST_SCE: begin
                mul_a     = 48'(r_emag);
                mul_b     = 48'(i_cfg.scale_one_four);
                mul_start = r_go && r_item.one_four;
            end
            ST_SCF: begin
                mul_a     = 48'(r_fmag);
                mul_b     = 48'(i_cfg.scale_one_four);
                mul_start = r_go;
            end
            ST_FS: begin
                mul_a     = 48'(r_fmag);
                mul_b     = 48'(i_cfg.force_scale);
                mul_start = r_go;
            end
            ST_DIVU: begin
                div_n     = 64'({r_item.dmag[r_c], 30'd0});
                div_d     = 64'(r_root);
                div_qbits = QB_UNIT;
                div_start = r_go;
            end
            ST_MU: begin
                mul_a     = 48'(r_fmag);
                mul_b     = 48'(r_u);
                mul_start = r_go;
            end
            default: begin
            end
        endcase
    end

    cbe_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mul_start),
        .i_a     (mul_a),
        .i_b     (mul_b),
        .o_done  (mul_done),
        .o_p     (mul_p)
    );

    cbe_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_n     (div_n),
        .i_d     (div_d),
        .i_qbits (div_qbits),
        .o_done  (div_done),
        .o_q     (div_q)
    );

    // result assembly
    always_comb begin
        e = r_item.qneg ? -48'sd0 - 48'(r_emag) : 48'(r_emag);
        for (int c = 0; c < 3; c++) begin
            fv[c] = (r_item.qneg ^ r_item.dneg[c]) ? -48'sd0 - 48'(r_fc[c]) : 48'(r_fc[c]);
        end
        s_wide = 49'(r_energy_sum) + 49'(e);
        if (s_wide[48] != s_wide[47]) begin
            s_sat = s_wide[48] ? MIN47 : MAX47;
        end else begin
            s_sat = s_wide[47:0];
        end
    end

    assign o_q_pop    = (r_state == ST_IDLE) && !i_q_empty;
    assign o_out_push = (r_state == ST_EMIT) && !i_out_full;

    always_comb begin
        o_out_data.force_x      = fv[0];
        o_out_data.force_y      = fv[1];
        o_out_data.force_z      = fv[2];
        o_out_data.pair_energy  = e;
        o_out_data.total_energy = s_sat;
        o_out_data.is_final     = r_item.last;
        o_out_data.too_close    = r_close;
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            ST_IDLE: begin
                r_item <= i_q_data;
                r_c    <= '0;
                r_sum2 <= '0;
            end
            ST_SQ: begin
                if (mul_done) begin
                    r_sum2 <= r_sum2 + mul_p[65:0];
                    r_c    <= (r_c == 2'd2) ? 2'd0 : r_c + 1'b1;
                end
            end
            ST_ROOT: begin
                if (r_go) begin
                    r_rad  <= {2'b00, r_sum2};
                    r_srem <= '0;
                    r_root <= '0;
                    r_scnt <= '0;
                end else begin
                    r_srem <= sge ? 35'(srem_t - strial) : srem_t[34:0];
                    r_root <= {r_root[32:0], sge};
                    r_rad  <= r_rad << 2;
                    r_scnt <= r_scnt + 1'b1;
                end
            end
            ST_CHECK: begin
                r_close <= (r_root < 34'(i_cfg.min_distance)) || (r_root == '0);
                r_emag  <= '0;
                r_fmag  <= '0;
                for (int c = 0; c < 3; c++) begin
                    r_fc[c] <= '0;
                end
            end
            ST_KQ: begin
                if (mul_done) begin
                    r_kq <= mul_p[54:0];
                end
            end
            ST_DIVE: begin
                if (div_done) begin
                    r_emag <= div_q[35:0];
                end
            end
            ST_DEN2: begin
                if (mul_done) begin
                    r_den2 <= mul_p[67:0];
                end
            end
            ST_DIVF: begin
                if (div_done) begin
                    r_fmag <= 47'(div_q[39:0]);
                end
            end
            ST_SCE: begin
                if (mul_done) begin
                    r_emag <= mul_p[51:16];
                end
            end
            ST_SCF: begin
                if (mul_done) begin
                    r_fmag <= 47'(mul_p[55:16]);
                end
            end
            ST_FS: begin
                if (mul_done) begin
                    r_fmag <= (mul_p[95:63] != '0) ? MAX47[46:0] : mul_p[62:16];
                end
            end
            ST_DIVU: begin
                if (div_done) begin
                    r_u <= div_q[30:0];
                end
            end
            ST_MU: begin
                if (mul_done) begin
                    r_fc[r_c] <= mul_p[76:30];
                    r_c       <= r_c + 1'b1;
                end
            end
            ST_EMIT: begin
            end
            default: begin
            end
        endcase
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_go         <= 1'b0;
            r_energy_sum <= '0;
        end else begin
            if (mul_start || div_start) begin
                r_go <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (!i_q_empty) begin
                        r_go    <= 1'b1;
                        r_state <= ST_SQ;
                    end
                end
                ST_SQ: begin
                    if (mul_done) begin
                        r_go <= 1'b1;
                        if (r_c == 2'd2) begin
                            r_state <= ST_ROOT;
                        end
                    end
                end
                ST_ROOT: begin
                    r_go <= 1'b0;
                    if (!r_go && r_scnt == 6'd33) begin
                        r_state <= ST_CHECK;
                    end
                end
                ST_CHECK: begin
                    if ((r_root < 34'(i_cfg.min_distance)) || (r_root == '0)) begin
                        r_state <= ST_EMIT;
                    end else begin
                        r_go    <= 1'b1;
                        r_state <= ST_KQ;
                    end
                end
                ST_KQ: begin
                    if (mul_done) begin
                        r_go    <= 1'b1;
                        r_state <= ST_DIVE;
                    end
                end
                ST_DIVE: begin
                    if (div_done) begin
                        r_go    <= 1'b1;
                        r_state <= ST_DEN2;
                    end
                end
                ST_DEN2: begin
                    if (mul_done) begin
                        r_go    <= 1'b1;
                        r_state <= ST_DIVF;
                    end
                end
                ST_DIVF: begin
                    if ((r_go && !den_small) || div_done) begin
                        r_go    <= 1'b1;
                        r_state <= ST_SCE;
                    end
                end
                ST_SCE: begin
                    if (r_go && !r_item.one_four) begin
                        r_go    <= 1'b1;
                        r_state <= ST_FS;
                    end else if (mul_done) begin
                        r_go    <= 1'b1;
                        r_state <= ST_SCF;
                    end
                end
                ST_SCF: begin
                    if (mul_done) begin
                        r_go    <= 1'b1;
                        r_state <= ST_FS;
                    end
                end
                ST_FS: begin
                    if (mul_done) begin
                        r_go    <= 1'b1;
                        r_state <= ST_DIVU;
                    end
                end
                ST_DIVU: begin
                    if (div_done) begin
                        r_go    <= 1'b1;
                        r_state <= ST_MU;
                    end
                end
                ST_MU: begin
                    if (mul_done) begin
                        r_go    <= 1'b1;
                        r_state <= (r_c == 2'd2) ? ST_EMIT : ST_DIVU;
                    end
                end
                ST_EMIT: begin
                    if (!i_out_full) begin
                        r_energy_sum <= r_item.last ? 48'sd0 : s_sat;
                        r_go         <= 1'b0;
                        r_state      <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

`ifndef SYNTHESIS
    a_skip_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_push && o_out_data.too_close |->
            o_out_data.pair_energy == '0 && o_out_data.force_x == '0 &&
            o_out_data.force_y == '0 && o_out_data.force_z == '0)
        else $error("skipped pair carries a non-zero result");

    a_sum_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && $past(o_out_push) && $past(o_out_data.is_final) |->
            r_energy_sum == '0)
        else $error("energy sum not cleared after final beat");

    a_div_owner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> r_state == ST_DIVE || r_state == ST_DIVF || r_state == ST_DIVU)
        else $error("divider finished outside a division step");

    a_mul_owner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mul_done |-> r_state == ST_SQ || r_state == ST_KQ || r_state == ST_DEN2 ||
            r_state == ST_SCE || r_state == ST_SCF || r_state == ST_FS ||
            r_state == ST_MU)
        else $error("multiplier finished outside a multiply step");
`endif
endmodule
`default_nettype wire

@@ src/buffered_coulomb_pair_energy_force.sv @@
// Top level of the buffered Coulomb pair energy and force block.
// One pair goes in per push beat and one result comes out per pop beat, in order. A front
// stage forms the separations and charge product and hands pairs on through a short queue;
// the back stage works one pair at a time on a shared 48x16 multiplier (an operand load and
// then three 16-bit digits per product) and a shared one-bit-per-cycle divider, with a
// two-bit-per-cycle square root. Its time per pair is dominated by the divider (energy,
// force and three direction components), and a 1-4 pair adds two scaling products; when
// the distance is too large for the force division that step is skipped. A pair skipped
// below the minimum distance leaves out the energy and force steps.
// Configuration writes are always ready and take effect at once; write them only while idle.
`default_nettype none
module buffered_coulomb_pair_energy_force
    import cbe_pkg::*;
#(
    parameter int QUEUE_DEPTH  = 2,
    parameter int RESULT_DEPTH = 2
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               push,
    output logic                    full,
    input  wire logic signed [31:0] i_first_x,
    input  wire logic signed [31:0] i_first_y,
    input  wire logic signed [31:0] i_first_z,
    input  wire logic signed [31:0] i_second_x,
    input  wire logic signed [31:0] i_second_y,
    input  wire logic signed [31:0] i_second_z,
    input  wire logic signed [15:0] i_first_charge,
    input  wire logic signed [15:0] i_second_charge,
    input  wire logic               i_pair_one_four,
    input  wire logic               i_pair_last,
    input  wire logic               i_cfg_valid,
    output logic                    o_cfg_ready,
    input  wire logic [1:0]         i_cfg_index,
    input  wire logic [31:0]        i_cfg_data,
    output logic                    empty,
    input  wire logic               pop,
    output logic signed [47:0]      o_force_x,
    output logic signed [47:0]      o_force_y,
    output logic signed [47:0]      o_force_z,
    output logic signed [47:0]      o_pair_energy,
    output logic signed [47:0]      o_total_energy,
    output logic                    o_is_final,
    output logic                    o_too_close
);
    t_cfg  r_cfg;
    t_pair front_pair, back_pair;
    logic  front_push, q_full, q_empty, q_pop;
    logic  out_push, out_full;
    logic [$bits(t_pair)-1:0]   q_dout;
    logic [$bits(t_result)-1:0] res_dout;
    t_result back_res, res;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.scale_one_four <= SCALE_ONE_FOUR_RST;
            r_cfg.force_scale    <= FORCE_SCALE_RST;
            r_cfg.min_distance   <= MIN_DISTANCE_RST;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_SCALE_ONE_FOUR: r_cfg.scale_one_four <= i_cfg_data[15:0];
                CFG_FORCE_SCALE:    r_cfg.force_scale    <= i_cfg_data;
                CFG_MIN_DISTANCE:   r_cfg.min_distance   <= i_cfg_data[15:0];
                default: begin
                end
            endcase
        end
    end

    cbe_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_push          (push),
        .o_full          (full),
        .i_first_x       (i_first_x),
        .i_first_y       (i_first_y),
        .i_first_z       (i_first_z),
        .i_second_x      (i_second_x),
        .i_second_y      (i_second_y),
        .i_second_z      (i_second_z),
        .i_first_charge  (i_first_charge),
        .i_second_charge (i_second_charge),
        .i_pair_one_four (i_pair_one_four),
        .i_pair_last     (i_pair_last),
        .i_q_full        (q_full),
        .o_q_push        (front_push),
        .o_pair          (front_pair)
    );

    cbe_fifo #(
        .WIDTH ($bits(t_pair)),
        .DEPTH (QUEUE_DEPTH)
    ) u_pair_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_push),
        .i_data  (front_pair),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_data  (q_dout),
        .o_empty (q_empty)
    );

    assign back_pair = t_pair'(q_dout);

    cbe_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_q_empty  (q_empty),
        .i_q_data   (back_pair),
        .o_q_pop    (q_pop),
        .i_out_full (out_full),
        .o_out_push (out_push),
        .o_out_data (back_res)
    );

    cbe_fifo #(
        .WIDTH ($bits(t_result)),
        .DEPTH (RESULT_DEPTH)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (out_push),
        .i_data  (back_res),
        .o_full  (out_full),
        .i_pop   (pop),
        .o_data  (res_dout),
        .o_empty (empty)
    );

    assign res            = t_result'(res_dout);
    assign o_force_x      = res.force_x;
    assign o_force_y      = res.force_y;
    assign o_force_z      = res.force_z;
    assign o_pair_energy  = res.pair_energy;
    assign o_total_energy = res.total_energy;
    assign o_is_final     = res.is_final;
    assign o_too_close    = res.too_close;
endmodule
`default_nettype wire
